// ----- design/gpr_pkg.sv -----
package gpr_pkg;

  localparam int unsigned GROUPS_DEF      = 1024;
  localparam int unsigned VALUE_WIDTH_DEF = 64;
  localparam int unsigned CMDQ_DEPTH      = 4;
  localparam int unsigned OUTQ_DEPTH      = 2;

  localparam int unsigned GI_W   = 10;
  localparam int unsigned VAL_W  = 64;
  localparam int unsigned GC_W   = 11;
  localparam int unsigned ET_W   = 4;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_GROUP_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_TYPE = 1'b1;

  localparam logic [GC_W-1:0] GROUP_COUNT_RST  = 11'd1024;
  localparam logic [ET_W-1:0] ELEMENT_TYPE_RST = 4'd7;

  localparam logic [ET_W-1:0] ET_BOOL = 4'd0;
  localparam logic [ET_W-1:0] ET_S8   = 4'd1;
  localparam logic [ET_W-1:0] ET_U8   = 4'd2;
  localparam logic [ET_W-1:0] ET_S16  = 4'd3;
  localparam logic [ET_W-1:0] ET_U16  = 4'd4;
  localparam logic [ET_W-1:0] ET_S32  = 4'd5;
  localparam logic [ET_W-1:0] ET_U32  = 4'd6;

  typedef enum logic [1:0] {
    OP_ACC   = 2'd0,
    OP_READ  = 2'd1,
    OP_START = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CMD_ACC   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_START = 2'd2,
    CMD_DROP  = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    logic [1:0]      op;
    logic [GI_W-1:0] group_index;
    logic [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] product;
    logic             dropped_flag;
  } out_item_t;

  typedef struct packed {
    logic [GC_W-1:0] group_count;
    logic [ET_W-1:0] element_type;
  } cfg_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [GI_W-1:0]  group;
    logic             in_range;
    logic             is_bool;
    logic [VAL_W-1:0] mask;
    logic [VAL_W-1:0] operand;
  } cmd_t;

  // element width mask, capped at the stored value width
  function automatic logic [VAL_W-1:0] elem_mask(logic [ET_W-1:0] et, int unsigned vw);
    int unsigned w;
    w = 64;
    if (et == ET_BOOL || et == ET_S8 || et == ET_U8) w = 8;
    else if (et == ET_S16 || et == ET_U16) w = 16;
    else if (et == ET_S32 || et == ET_U32) w = 32;
    if (w > vw) w = vw;
    if (w >= 64) return '1;
    return (64'(1) << w) - 64'(1);
  endfunction

endpackage

// ----- design/gpr_queue.sv -----
module gpr_queue #(
  parameter type         T     = logic,
  parameter int unsigned DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  T     din,
  output logic full,
  input  logic pop,
  output T     dout,
  output logic empty
);

  localparam int unsigned PW = $clog2(DEPTH);

  T             slots [DEPTH];
  logic [PW-1:0] wr_r;
  logic [PW-1:0] rd_r;
  logic [PW:0]   cnt_r;
  logic          do_push;
  logic          do_pop;

  assign full    = (cnt_r == (PW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= wr_r + PW'(1);
      if (do_pop)  rd_r <= rd_r + PW'(1);
      if (do_push && !do_pop)      cnt_r <= cnt_r + (PW+1)'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_r] <= din;
  end

endmodule

// ----- design/gpr_front.sv -----
module gpr_front import gpr_pkg::*; #(
  parameter int unsigned GROUPS      = GROUPS_DEF,
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     in_push,
  input  in_item_t in_item,
  output logic     in_full,
  input  logic     cmd_pop,
  output cmd_t     cmd,
  output logic     cmd_empty
);

  cmd_t             cls;
  logic [VAL_W-1:0] m;
  logic [VAL_W-1:0] vm;
  logic             q_push;

  always_comb begin
    m  = elem_mask(cfg.element_type, VALUE_WIDTH);
    vm = in_item.value & m;
    cls.group    = in_item.group_index;
    cls.in_range = ({1'b0, in_item.group_index} < cfg.group_count)
                   && (32'(in_item.group_index) < GROUPS);
    cls.is_bool  = (cfg.element_type == ET_BOOL);
    cls.mask     = m;
    cls.operand  = cls.is_bool ? VAL_W'(vm != '0) : vm;
    unique case (op_t'(in_item.op))
      OP_ACC:   cls.kind = cls.in_range ? CMD_ACC : CMD_DROP;
      OP_READ:  cls.kind = CMD_READ;
      OP_START: cls.kind = CMD_START;
      default:  cls.kind = CMD_DROP;
    endcase
  end

  // unused op is taken and discarded
  assign q_push = in_push && !in_full && (op_t'(in_item.op) != OP_NONE);

  gpr_queue #(.T(cmd_t), .DEPTH(CMDQ_DEPTH)) u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (cls),
    .full  (in_full),
    .pop   (cmd_pop),
    .dout  (cmd),
    .empty (cmd_empty)
  );

endmodule

// ----- design/gpr_back.sv -----
module gpr_back import gpr_pkg::*; #(
  parameter int unsigned GROUPS      = GROUPS_DEF,
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_t      cmd,
  input  logic      cmd_empty,
  output logic      cmd_pop,
  output logic      res_push,
  output out_item_t res,
  input  logic      res_full
);

  localparam int unsigned AW = $clog2(GROUPS);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LOOK  = 6'b000010,
    S_MUL1  = 6'b000100,
    S_MUL2  = 6'b001000,
    S_WR    = 6'b010000,
    S_CLEAR = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [VALUE_WIDTH-1:0] prod_mem  [GROUPS];
  logic                   touch_mem [GROUPS];
  logic [VALUE_WIDTH-1:0] pm_rd_r;
  logic                   tm_rd_r;

  cmd_t             cmd_r;
  logic [AW-1:0]    clr_r;
  logic             dropped_r;
  logic [VAL_W-1:0] a_r;
  logic [VAL_W-1:0] lo_r;
  logic [31:0]      cross_r;

  logic             rd_en;
  logic             pm_we;
  logic [VALUE_WIDTH-1:0] pm_wd;
  logic             tm_we;
  logic [AW-1:0]    tm_wa;
  logic             tm_wd;
  logic [VAL_W-1:0] old;
  logic [VAL_W-1:0] prod_full;
  logic [31:0]      mul_a;
  logic [31:0]      mul_b;
  logic [63:0]      mul_p;

  assign old       = tm_rd_r ? VAL_W'(pm_rd_r) : VAL_W'(1);
  assign prod_full = (lo_r + {cross_r, 32'd0}) & cmd_r.mask;
  assign mul_p     = 64'(mul_a) * 64'(mul_b);

  always_comb begin
    res.dropped_flag = dropped_r;
    if (cmd_r.in_range && tm_rd_r)
      res.product = cmd_r.is_bool ? VAL_W'(pm_rd_r[0]) : (VAL_W'(pm_rd_r) & cmd_r.mask);
    else
      res.product = VAL_W'(1);
  end

  always_comb begin
    state_nxt = state_r;
    cmd_pop   = 1'b0;
    rd_en     = 1'b0;
    res_push  = 1'b0;
    pm_we     = 1'b0;
    pm_wd     = VALUE_WIDTH'(prod_full);
    tm_we     = 1'b0;
    tm_wa     = AW'(cmd_r.group);
    tm_wd     = 1'b1;
    mul_a     = a_r[31:0];
    mul_b     = cmd_r.operand[63:32];
    unique case (state_r)
      S_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          unique case (cmd.kind)
            CMD_ACC, CMD_READ: begin
              rd_en     = 1'b1;
              state_nxt = S_LOOK;
            end
            CMD_START: state_nxt = S_CLEAR;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_LOOK: begin
        mul_a = old[31:0];
        mul_b = cmd_r.operand[31:0];
        if (cmd_r.kind == CMD_READ) begin
          // hold until the result queue has room
          res_push = !res_full;
          if (!res_full) state_nxt = S_IDLE;
        end else if (cmd_r.is_bool) begin
          pm_we     = 1'b1;
          pm_wd     = VALUE_WIDTH'(old[0] & cmd_r.operand[0]);
          tm_we     = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_MUL1;
        end
      end
      S_MUL1: state_nxt = S_MUL2;
      S_MUL2: begin
        mul_a     = a_r[63:32];
        mul_b     = cmd_r.operand[31:0];
        state_nxt = S_WR;
      end
      S_WR: begin
        pm_we     = 1'b1;
        tm_we     = 1'b1;
        state_nxt = S_IDLE;
      end
      S_CLEAR: begin
        tm_we = 1'b1;
        tm_wa = clr_r;
        tm_wd = 1'b0;
        if (clr_r == AW'(GROUPS - 1)) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_r     <= '0;
      dropped_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_r <= clr_r + AW'(1);
      if (cmd_pop && cmd.kind == CMD_START) begin
        clr_r     <= '0;
        dropped_r <= 1'b0;
      end
      if (cmd_pop && cmd.kind == CMD_DROP) dropped_r <= 1'b1;
    end
  end

  // low 64 bits of the product from three 32x32 partial products
  always_ff @(posedge clk) begin
    if (cmd_pop) cmd_r <= cmd;
    unique case (state_r)
      S_LOOK: begin
        a_r  <= old;
        lo_r <= mul_p;
      end
      S_MUL1:  cross_r <= mul_p[31:0];
      S_MUL2:  cross_r <= cross_r + mul_p[31:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pm_we) prod_mem[AW'(cmd_r.group)] <= pm_wd;
    if (rd_en) pm_rd_r <= prod_mem[AW'(cmd.group)];
  end

  always_ff @(posedge clk) begin
    if (tm_we) touch_mem[tm_wa] <= tm_wd;
    if (rd_en) tm_rd_r <= touch_mem[AW'(cmd.group)];
  end

endmodule

// ----- design/grouped_product_reduction_top.sv -----
// Channel   Direction  Handshake               Payload
// in_       input      in_push / in_full       in_item  (op, group_index, value)
// out_      output     out_empty / out_pop     out_item (product, dropped_flag)
// cfg_      input      cfg_we                  cfg_index, cfg_wdata
//
// Items go one at a time through the back sequencer: a read or boolean accumulate
// passes S_IDLE, S_LOOK; an integer accumulate S_IDLE, S_LOOK, S_MUL1, S_MUL2, S_WR
// (one 32x32 multiplier used over three partial products); a dropped one S_IDLE;
// a start S_IDLE, S_CLEAR. Start and reset run a clearing pass over all touched bits.
// Up to CMDQ_DEPTH items queue ahead of the sequencer; in_full rises when full.
// A read result waits in the result queue; the sequencer holds while it is full.
module grouped_product_reduction_top import gpr_pkg::*; #(
  parameter int unsigned GROUPS      = GROUPS_DEF,
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  input  in_item_t              in_item,
  output logic                  in_full,
  output logic                  out_empty,
  input  logic                  out_pop,
  output out_item_t             out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [GC_W-1:0] group_count_r;
  logic [ET_W-1:0] element_type_r;
  cfg_t            cfg;
  cmd_t            cmd;
  logic            cmd_pop;
  logic            cmd_empty;
  logic            res_push;
  logic            res_full;
  out_item_t       res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_count_r  <= GROUP_COUNT_RST;
      element_type_r <= ELEMENT_TYPE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GROUP_COUNT:  group_count_r  <= cfg_wdata[GC_W-1:0];
        CFG_ELEMENT_TYPE: element_type_r <= cfg_wdata[ET_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.group_count  = group_count_r;
  assign cfg.element_type = element_type_r;

  gpr_front #(.GROUPS(GROUPS), .VALUE_WIDTH(VALUE_WIDTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_push   (in_push),
    .in_item   (in_item),
    .in_full   (in_full),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .cmd_empty (cmd_empty)
  );

  gpr_back #(.GROUPS(GROUPS), .VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_push  (res_push),
    .res       (res),
    .res_full  (res_full)
  );

  gpr_queue #(.T(out_item_t), .DEPTH(OUTQ_DEPTH)) u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res),
    .full  (res_full),
    .pop   (out_pop),
    .dout  (out_item),
    .empty (out_empty)
  );

  a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into a full result queue");

  a_cmd_avail: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> !cmd_empty)
    else $error("command popped from an empty queue");

  a_read_one: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |=> !res_push)
    else $error("one read produced two results");

  a_cfg_gc: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && cfg_we && cfg_index == CFG_GROUP_COUNT
      |=> group_count_r == $past(cfg_wdata[GC_W-1:0]))
    else $error("group count write lost");

endmodule
